>>> sv/rfdm_pkg.sv
package rfdm_pkg;

	// Descriptor store depth and pool addressing.
	localparam int QUEUE_DEPTH    = 16;
	localparam int POOL_ADDR_BITS = 21;

	// Field widths.
	localparam int LEN_W  = 22;
	localparam int POS_W  = POOL_ADDR_BITS;
	localparam int POOL_W = POOL_ADDR_BITS + 1;
	localparam int SUM_W  = LEN_W + 1;
	localparam int CNT_W  = 5;
	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int MAXE_W = 5;
	localparam int STAT_W = 2;
	localparam int CFG_IDX_W = 2;

	// Largest usable pool, one past the highest byte offset.
	localparam logic [POOL_W-1:0] POOL_MAX = {1'b1, {POOL_ADDR_BITS{1'b0}}};

	// Reset values of the configuration registers.
	localparam logic [LEN_W-1:0]  POOL_SIZE_RESET   = LEN_W'(2097152);
	localparam logic [MAXE_W-1:0] MAX_ENTRIES_RESET = MAXE_W'(10);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = CFG_IDX_W'(1);

	// Request actions.
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_PULL = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_REJECT = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY  = 2'd2;

	// Depth of the command queue between front and back.
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Classified command handed from front to back.
	typedef enum logic [1:0] {
		OP_REJECT = 2'd0,
		OP_PUSH   = 2'd1,
		OP_PULL   = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [POS_W-1:0]  start;
		logic [LEN_W-1:0]  len;
	} op_t;

	// Command queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> sv/rfdm_front.sv
module rfdm_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       action,
	input  logic [rfdm_pkg::LEN_W-1:0] frame_len,
	input  logic [rfdm_pkg::LEN_W-1:0] pool_size,
	input  rfdm_pkg::q_stat_t          q_stat,
	output logic                       busy,
	output logic                       q_wr,
	output rfdm_pkg::op_t              q_wdata
);

	logic [rfdm_pkg::POS_W-1:0]  wp_q;
	logic [rfdm_pkg::POS_W-1:0]  wp_next;
	logic [rfdm_pkg::POOL_W-1:0] pool_eff;
	logic [rfdm_pkg::SUM_W-1:0]  end_sum;
	logic                        rejected;

	// The front takes a request whenever the queue has room.
	assign busy = q_stat.full;
	assign q_wr = start && !busy;

	// Clamp the pool to the addressable range.
	always_comb begin
		if (pool_size > rfdm_pkg::LEN_W'(rfdm_pkg::POOL_MAX)) begin
			pool_eff = rfdm_pkg::POOL_MAX;
		end else begin
			pool_eff = rfdm_pkg::POOL_W'(pool_size);
		end
	end

	// Classify the request and place a pushed frame in the pool.
	always_comb begin
		end_sum  = rfdm_pkg::SUM_W'(wp_q) + rfdm_pkg::SUM_W'(frame_len);
		rejected = (frame_len == '0) || (rfdm_pkg::SUM_W'(frame_len) > rfdm_pkg::SUM_W'(pool_eff));
		wp_next  = wp_q;
		q_wdata.kind  = rfdm_pkg::OP_PULL;
		q_wdata.start = '0;
		q_wdata.len   = frame_len;
		if (action == rfdm_pkg::ACT_PUSH) begin
			if (rejected) begin
				q_wdata.kind = rfdm_pkg::OP_REJECT;
			end else begin
				q_wdata.kind = rfdm_pkg::OP_PUSH;
				if (end_sum > rfdm_pkg::SUM_W'(pool_eff)) begin
					// Frame would run past the end: wrap to offset zero.
					q_wdata.start = '0;
					if (rfdm_pkg::SUM_W'(frame_len) == rfdm_pkg::SUM_W'(pool_eff)) begin
						wp_next = '0;
					end else begin
						wp_next = frame_len[rfdm_pkg::POS_W-1:0];
					end
				end else if (end_sum == rfdm_pkg::SUM_W'(pool_eff)) begin
					q_wdata.start = wp_q;
					wp_next = '0;
				end else begin
					q_wdata.start = wp_q;
					wp_next = end_sum[rfdm_pkg::POS_W-1:0];
				end
			end
		end
	end

	// Write position moves only on an accepted push that fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (q_wr && (q_wdata.kind == rfdm_pkg::OP_PUSH)) begin
			wp_q <= wp_next;
		end
	end

endmodule

>>> sv/rfdm_queue.sv
module rfdm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  rfdm_pkg::op_t     wdata,
	input  logic              rd,
	output rfdm_pkg::op_t     rdata,
	output rfdm_pkg::q_stat_t stat
);

	rfdm_pkg::op_t                   mem_q [rfdm_pkg::FIFO_DEPTH];
	logic [rfdm_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [rfdm_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [rfdm_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic                            do_wr;
	logic                            do_rd;

	assign stat.full  = (cnt_q == rfdm_pkg::FIFO_CNT_W'(rfdm_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_wr = wr && !stat.full;
	assign do_rd = rd && !stat.empty;
	assign rdata = mem_q[rd_ptr_q];

	// Pointer and occupancy bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				if (wr_ptr_q == rfdm_pkg::FIFO_PTR_W'(rfdm_pkg::FIFO_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_rd) begin
				if (rd_ptr_q == rfdm_pkg::FIFO_PTR_W'(rfdm_pkg::FIFO_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> sv/rfdm_back.sv
module rfdm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rfdm_pkg::MAXE_W-1:0] max_entries,
	input  rfdm_pkg::q_stat_t           q_stat,
	input  rfdm_pkg::op_t               q_rdata,
	output logic                        q_rd,
	output logic                        done,
	output logic [rfdm_pkg::STAT_W-1:0] status,
	output logic [rfdm_pkg::POS_W-1:0]  region_start,
	output logic [rfdm_pkg::LEN_W-1:0]  region_len,
	output logic [rfdm_pkg::CNT_W-1:0]  evicted,
	output logic [rfdm_pkg::CNT_W-1:0]  entries_left
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EVICT = 3'b010,
		ST_TRIM  = 3'b100
	} state_t;

	state_t                       state_q;
	logic [rfdm_pkg::IDX_W-1:0]   head_q;
	logic [rfdm_pkg::CNT_W-1:0]   count_q;
	logic [rfdm_pkg::POS_W-1:0]   desc_start_q [rfdm_pkg::QUEUE_DEPTH];
	logic [rfdm_pkg::LEN_W-1:0]   desc_len_q   [rfdm_pkg::QUEUE_DEPTH];
	logic [rfdm_pkg::POS_W-1:0]   cur_start_q;
	logic [rfdm_pkg::LEN_W-1:0]   cur_len_q;
	logic [rfdm_pkg::CNT_W-1:0]   evict_q;

	logic                         done_q;
	logic [rfdm_pkg::STAT_W-1:0]  status_q;
	logic [rfdm_pkg::POS_W-1:0]   rstart_q;
	logic [rfdm_pkg::LEN_W-1:0]   rlen_q;
	logic [rfdm_pkg::CNT_W-1:0]   evicted_q;
	logic [rfdm_pkg::CNT_W-1:0]   left_q;

	logic [rfdm_pkg::CNT_W-1:0]   limit;
	logic [rfdm_pkg::IDX_W-1:0]   head_next;
	logic [rfdm_pkg::CNT_W:0]     tail_sum;
	logic [rfdm_pkg::IDX_W-1:0]   tail;
	logic [rfdm_pkg::SUM_W-1:0]   front_lo;
	logic [rfdm_pkg::SUM_W-1:0]   front_hi;
	logic [rfdm_pkg::SUM_W-1:0]   cur_lo;
	logic [rfdm_pkg::SUM_W-1:0]   cur_hi;
	logic                         front_ov;
	logic                         append;

	assign done         = done_q;
	assign status       = status_q;
	assign region_start = rstart_q;
	assign region_len   = rlen_q;
	assign evicted      = evicted_q;
	assign entries_left = left_q;

	// Take the next command only when no push is being carried out.
	assign q_rd = (state_q == ST_IDLE) && !q_stat.empty;

	// Effective descriptor limit, clamped to one through the store depth.
	always_comb begin
		if (max_entries == '0) begin
			limit = rfdm_pkg::CNT_W'(1);
		end else if (max_entries > rfdm_pkg::MAXE_W'(rfdm_pkg::QUEUE_DEPTH)) begin
			limit = rfdm_pkg::CNT_W'(rfdm_pkg::QUEUE_DEPTH);
		end else begin
			limit = rfdm_pkg::CNT_W'(max_entries);
		end
	end

	// Ring index arithmetic for the descriptor store.
	always_comb begin
		if (head_q == rfdm_pkg::IDX_W'(rfdm_pkg::QUEUE_DEPTH - 1)) begin
			head_next = '0;
		end else begin
			head_next = head_q + 1'b1;
		end
		tail_sum = (rfdm_pkg::CNT_W + 1)'(head_q) + (rfdm_pkg::CNT_W + 1)'(count_q);
		if (tail_sum >= (rfdm_pkg::CNT_W + 1)'(rfdm_pkg::QUEUE_DEPTH)) begin
			tail = rfdm_pkg::IDX_W'(tail_sum - (rfdm_pkg::CNT_W + 1)'(rfdm_pkg::QUEUE_DEPTH));
		end else begin
			tail = tail_sum[rfdm_pkg::IDX_W-1:0];
		end
	end

	// Overlap test between the oldest descriptor and the new frame.
	always_comb begin
		front_lo = rfdm_pkg::SUM_W'(desc_start_q[head_q]);
		front_hi = front_lo + rfdm_pkg::SUM_W'(desc_len_q[head_q]);
		cur_lo   = rfdm_pkg::SUM_W'(cur_start_q);
		cur_hi   = cur_lo + rfdm_pkg::SUM_W'(cur_len_q);
		front_ov = !((front_lo >= cur_hi) || (front_hi <= cur_lo));
	end

	assign append = (state_q == ST_TRIM) && (count_q < limit);

	// Sequencer: pulls and rejects finish at once, a push walks the front.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
			evict_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_rd) begin
						unique case (q_rdata.kind)
							rfdm_pkg::OP_PUSH: begin
								evict_q <= '0;
								state_q <= ST_EVICT;
							end
							rfdm_pkg::OP_PULL: begin
								done_q <= 1'b1;
								if (count_q != '0) begin
									head_q  <= head_next;
									count_q <= count_q - 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_EVICT: begin
					if ((count_q != '0) && front_ov) begin
						head_q  <= head_next;
						count_q <= count_q - 1'b1;
						evict_q <= evict_q + 1'b1;
					end else begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					if (append) begin
						count_q <= count_q + 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						head_q  <= head_next;
						count_q <= count_q - 1'b1;
						evict_q <= evict_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Current push and result payload.
	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_start_q <= q_rdata.start;
			cur_len_q   <= q_rdata.len;
			evicted_q   <= '0;
			unique case (q_rdata.kind)
				rfdm_pkg::OP_PULL: begin
					if (count_q == '0) begin
						status_q <= rfdm_pkg::STATUS_EMPTY;
						rstart_q <= '0;
						rlen_q   <= '0;
						left_q   <= '0;
					end else begin
						status_q <= rfdm_pkg::STATUS_OK;
						rstart_q <= desc_start_q[head_q];
						rlen_q   <= desc_len_q[head_q];
						left_q   <= count_q - 1'b1;
					end
				end
				rfdm_pkg::OP_REJECT: begin
					status_q <= rfdm_pkg::STATUS_REJECT;
					rstart_q <= '0;
					rlen_q   <= '0;
					left_q   <= count_q;
				end
				default: begin
				end
			endcase
		end else if (append) begin
			status_q  <= rfdm_pkg::STATUS_OK;
			rstart_q  <= cur_start_q;
			rlen_q    <= cur_len_q;
			evicted_q <= evict_q;
			left_q    <= count_q + 1'b1;
		end
	end

	// Descriptor store, written at the tail on append.
	always_ff @(posedge clk) begin
		if (append) begin
			desc_start_q[tail] <= cur_start_q;
			desc_len_q[tail]   <= cur_len_q;
		end
	end

endmodule

>>> sv/ring_frame_descriptor_manager_top.sv
// Ring frame descriptor manager.
// Requests enter on start/action/frame_len and are taken at a clock edge with
// start high and busy low. A push places a frame in the circular pool and
// queues its descriptor; a pull returns and removes the oldest descriptor.
// Every request yields one result, shown for one cycle with done high, on
// status, region_start, region_len, evicted and entries_left, in request order.
// The receiver cannot stall, so results are never held back.
// Configuration uses cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// is the pool size, index 1 the descriptor limit. Write only while idle.
// A taken request is written into the command queue; the back end reads it
// from there and registers its result. For a push, the back end walks the
// oldest descriptors one per cycle, dropping those it evicts, and appends the
// new one; it takes no further command until that push is done, and otherwise
// serves one pull or reject per cycle. A two-entry command queue lets the front
// keep taking requests while the back end works; busy rises when it is full.
// Reset clears the queue, the write position and the command queue, and loads
// a pool of 2097152 bytes and a limit of ten descriptors.
module ring_frame_descriptor_manager_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           action,
	input  logic [rfdm_pkg::LEN_W-1:0]     frame_len,
	output logic                           done,
	output logic [rfdm_pkg::STAT_W-1:0]    status,
	output logic [rfdm_pkg::POS_W-1:0]     region_start,
	output logic [rfdm_pkg::LEN_W-1:0]     region_len,
	output logic [rfdm_pkg::CNT_W-1:0]     evicted,
	output logic [rfdm_pkg::CNT_W-1:0]     entries_left,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rfdm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfdm_pkg::LEN_W-1:0]     cfg_data
);

	logic [rfdm_pkg::LEN_W-1:0]  pool_size_q;
	logic [rfdm_pkg::MAXE_W-1:0] max_entries_q;
	logic                        q_wr;
	logic                        q_rd;
	rfdm_pkg::op_t               q_wdata;
	rfdm_pkg::op_t               q_rdata;
	rfdm_pkg::q_stat_t           q_stat;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q   <= rfdm_pkg::POOL_SIZE_RESET;
			max_entries_q <= rfdm_pkg::MAX_ENTRIES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == rfdm_pkg::CFG_POOL_SIZE) begin
				pool_size_q <= cfg_data;
			end else if (cfg_index == rfdm_pkg::CFG_MAX_ENTRIES) begin
				max_entries_q <= cfg_data[rfdm_pkg::MAXE_W-1:0];
			end
		end
	end

	rfdm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.frame_len (frame_len),
		.pool_size (pool_size_q),
		.q_stat    (q_stat),
		.busy      (busy),
		.q_wr      (q_wr),
		.q_wdata   (q_wdata)
	);

	rfdm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	rfdm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_entries  (max_entries_q),
		.q_stat       (q_stat),
		.q_rdata      (q_rdata),
		.q_rd         (q_rd),
		.done         (done),
		.status       (status),
		.region_start (region_start),
		.region_len   (region_len),
		.evicted      (evicted),
		.entries_left (entries_left)
	);

endmodule

>>> sv/rfdm_checker.sv
module rfdm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           done,
	input logic [rfdm_pkg::STAT_W-1:0]    status,
	input logic [rfdm_pkg::POS_W-1:0]     region_start,
	input logic [rfdm_pkg::LEN_W-1:0]     region_len,
	input logic [rfdm_pkg::CNT_W-1:0]     evicted,
	input logic [rfdm_pkg::CNT_W-1:0]     entries_left
);

	// A rejected push places nothing and drops nothing.
	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == rfdm_pkg::STATUS_REJECT)) |->
		((region_len == '0) && (region_start == '0) && (evicted == '0)))
		else $error("rejected push reported a region or evictions");

	// A pull on an empty queue leaves the queue empty and returns no region.
	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == rfdm_pkg::STATUS_EMPTY)) |->
		((entries_left == '0) && (region_len == '0) && (evicted == '0)))
		else $error("empty pull reported queued entries or a region");

	// A successful transaction always carries a frame of nonzero length.
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == rfdm_pkg::STATUS_OK)) |-> (region_len != '0))
		else $error("successful result with zero length");

	// The queue never reports more entries than the store holds.
	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entries_left <= rfdm_pkg::CNT_W'(rfdm_pkg::QUEUE_DEPTH)))
		else $error("entry count beyond store depth");

endmodule

bind ring_frame_descriptor_manager_top rfdm_checker u_rfdm_checker (.*);

>>> sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rfdm_pkg::*;

	// Unused configuration index; writes to it must leave both registers alone.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
	localparam int SETTLE_CYCLES = 24;

	// One result transaction as seen on the output ports.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  region_start;
		logic [LEN_W-1:0]  region_len;
		logic [CNT_W-1:0]  evicted;
		logic [CNT_W-1:0]  entries_left;
	} frame_result_t;

	// Scoreboard: mirrors the pool and descriptor ring and checks each result.
	class ring_scoreboard;
		logic [LEN_W-1:0]  pool_reg;
		logic [MAXE_W-1:0] limit_reg;
		longint unsigned   wpos;
		longint unsigned   slot_start[QUEUE_DEPTH];
		longint unsigned   slot_len[QUEUE_DEPTH];
		int unsigned       head;
		int unsigned       count;
		frame_result_t     due_results[$];
		int unsigned       fails;
		int unsigned       n_placed, n_rejected, n_pulled, n_empty, n_cfg;
		int unsigned       most_evicted;

		function new();
			pool_reg     = POOL_SIZE_RESET;
			limit_reg    = MAX_ENTRIES_RESET;
			wpos         = 0;
			head         = 0;
			count        = 0;
			fails        = 0;
			n_placed     = 0;
			n_rejected   = 0;
			n_pulled     = 0;
			n_empty      = 0;
			n_cfg        = 0;
			most_evicted = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
			n_cfg++;
			if (idx == CFG_POOL_SIZE)
				pool_reg = data;
			else if (idx == CFG_MAX_ENTRIES)
				limit_reg = data[MAXE_W-1:0];
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction

		function void drop_oldest();
			head = (head + 1) % QUEUE_DEPTH;
			count--;
		endfunction

		// Works out the result of one accepted request and updates the mirror.
		function void note_request(logic act, logic [LEN_W-1:0] len);
			frame_result_t   r;
			longint unsigned pool, lim, place, ev, lo, hi;
			int unsigned     tail;
			r    = '0;
			ev   = 0;
			pool = pool_reg;
			lim  = limit_reg;
			if (pool > POOL_MAX)
				pool = POOL_MAX;
			if (lim == 0)
				lim = 1;
			if (lim > QUEUE_DEPTH)
				lim = QUEUE_DEPTH;
			if (act == ACT_PUSH) begin
				if (len == 0 || len > pool) begin
					r.status = STATUS_REJECT;
					n_rejected++;
				end else begin
					// Wrap to the pool start when the frame would run past the end.
					if (wpos + len > pool) begin
						place = 0;
						wpos  = len;
					end else begin
						place = wpos;
						wpos  = wpos + len;
					end
					if (wpos == pool)
						wpos = 0;
					// Drop front descriptors that the new frame overlaps.
					while (count > 0) begin
						lo = slot_start[head];
						hi = lo + slot_len[head];
						if (lo >= place + len || hi <= place)
							break;
						drop_oldest();
						ev++;
					end
					// Make room so the count after appending stays within the limit.
					while (count >= lim) begin
						drop_oldest();
						ev++;
					end
					tail = (head + count) % QUEUE_DEPTH;
					slot_start[tail] = place;
					slot_len[tail]   = len;
					count++;
					r.status       = STATUS_OK;
					r.region_start = place[POS_W-1:0];
					r.region_len   = len;
					r.evicted      = ev[CNT_W-1:0];
					if (ev > most_evicted)
						most_evicted = ev;
					n_placed++;
				end
			end else begin
				if (count == 0) begin
					r.status = STATUS_EMPTY;
					n_empty++;
				end else begin
					r.status       = STATUS_OK;
					r.region_start = slot_start[head][POS_W-1:0];
					r.region_len   = slot_len[head][LEN_W-1:0];
					drop_oldest();
					n_pulled++;
				end
			end
			r.entries_left = count[CNT_W-1:0];
			due_results.insert(due_results.size(), r);
		endfunction

		// Compares one result transaction with the oldest expected one.
		function void check_result(frame_result_t got);
			frame_result_t want;
			if (due_results.size() == 0) begin
				$error("result with no request outstanding");
				fails++;
				return;
			end
			want = due_results[0];
			due_results.delete(0);
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fails++;
			end
			if (got.region_start !== want.region_start) begin
				$error("region_start: expected %0d, got %0d",
				       want.region_start, got.region_start);
				fails++;
			end
			if (got.region_len !== want.region_len) begin
				$error("region_len: expected %0d, got %0d", want.region_len, got.region_len);
				fails++;
			end
			if (got.evicted !== want.evicted) begin
				$error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
				fails++;
			end
			if (got.entries_left !== want.entries_left) begin
				$error("entries_left: expected %0d, got %0d",
				       want.entries_left, got.entries_left);
				fails++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              action    = ACT_PUSH;
	logic [LEN_W-1:0]  frame_len = '0;
	logic              cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_POOL_SIZE;
	logic [LEN_W-1:0]  cfg_data  = '0;
	logic              busy, done, cfg_ready;
	logic [STAT_W-1:0] status;
	logic [POS_W-1:0]  region_start;
	logic [LEN_W-1:0]  region_len;
	logic [CNT_W-1:0]  evicted;
	logic [CNT_W-1:0]  entries_left;

	ring_scoreboard sb;

	ring_frame_descriptor_manager_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.frame_len    (frame_len),
		.done         (done),
		.status       (status),
		.region_start (region_start),
		.region_len   (region_len),
		.evicted      (evicted),
		.entries_left (entries_left),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	// Result monitor: a result is taken at the edge that ends its strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{status, region_start, region_len, evicted, entries_left});
	end

	// Presents one request and holds it until the block takes it. Start stays
	// high when no gap follows, so back-to-back requests need no extra edge.
	task automatic send_request(input logic act, input logic [LEN_W-1:0] len, input int gap);
		start     <= 1'b1;
		action    <= act;
		frame_len <= len;
		do @(posedge clk); while (busy);
		sb.note_request(act, len);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every outstanding result has come back.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	// Writes both registers; unused high bits of the limit carry random data.
	task automatic set_config(input logic [LEN_W-1:0] pool, input logic [MAXE_W-1:0] lim);
		logic [LEN_W-1:0] lim_word;
		lim_word = {LEN_W'($urandom)} & ~LEN_W'(2**MAXE_W - 1);
		write_reg(CFG_POOL_SIZE, pool);
		write_reg(CFG_MAX_ENTRIES, lim_word | LEN_W'(lim));
		cfg_valid <= 1'b0;
	endtask

	// Random traffic: mostly well-formed pushes and pulls, some malformed ones.
	task automatic run_phase(input int n, input int pull_pct, input int unsigned max_len);
		logic             act;
		logic [LEN_W-1:0] len;
		int               r, gap;
		bit               quiet;
		quiet = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (i % 32 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 6) begin
				act = ACT_PUSH;
				len = LEN_W'($urandom);
			end else if (r < 8) begin
				act = ACT_PUSH;
				len = '0;
			end else if (r < 8 + pull_pct) begin
				act = ACT_PULL;
				len = LEN_W'($urandom);
			end else begin
				act = ACT_PUSH;
				len = LEN_W'($urandom_range(1, max_len));
			end
			r = $urandom_range(0, 99);
			if (quiet || r < 60)
				gap = 0;
			else if (r < 92)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(8, 30);
			send_request(act, len, gap);
		end
		drain();
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset pool, empty pulls, length extremes, exact fit.
		send_request(ACT_PULL, '0, 0);
		send_request(ACT_PUSH, '0, 0);
		send_request(ACT_PUSH, LEN_W'(POOL_MAX), 0);
		send_request(ACT_PUSH, LEN_W'(POOL_MAX) + 1, 1);
		send_request(ACT_PUSH, '1, 0);
		send_request(ACT_PUSH, LEN_W'(1), 0);
		send_request(ACT_PUSH, LEN_W'(POOL_MAX) - 1, 2);
		send_request(ACT_PULL, '1, 0);
		send_request(ACT_PULL, '0, 0);
		send_request(ACT_PULL, '0, 0);
		drain();

		// Oversized pool register saturates to the addressable size.
		set_config('1, MAXE_W'(10));
		send_request(ACT_PUSH, LEN_W'(POOL_MAX), 0);
		send_request(ACT_PUSH, LEN_W'(3), 0);
		drain();

		// Small pool: wrap to start and overlap eviction.
		set_config(LEN_W'(100), MAXE_W'(3));
		send_request(ACT_PUSH, LEN_W'(30), 0);
		send_request(ACT_PUSH, LEN_W'(30), 0);
		send_request(ACT_PUSH, LEN_W'(30), 0);
		send_request(ACT_PUSH, LEN_W'(30), 0);
		drain();

		// Limit of zero acts as one; limit above the depth acts as the depth.
		set_config(LEN_W'(100), MAXE_W'(0));
		send_request(ACT_PUSH, LEN_W'(5), 0);
		drain();
		set_config(LEN_W'(1), '1);
		send_request(ACT_PUSH, LEN_W'(1), 0);
		send_request(ACT_PUSH, LEN_W'(1), 0);
		drain();

		// Zero pool rejects every push.
		set_config('0, MAXE_W'(16));
		send_request(ACT_PUSH, LEN_W'(1), 0);
		send_request(ACT_PULL, '0, 0);
		drain();

		// Limit lowered below the current count.
		set_config(LEN_W'(1000), MAXE_W'(8));
		repeat (4) send_request(ACT_PUSH, LEN_W'(10), 0);
		drain();
		set_config(LEN_W'(1000), MAXE_W'(2));
		send_request(ACT_PUSH, LEN_W'(10), 0);
		drain();

		// Random phases over a range of pool sizes and limits.
		set_config(POOL_SIZE_RESET, MAX_ENTRIES_RESET);
		run_phase(100, 30, 700000);
		set_config(LEN_W'(5000), MAXE_W'(16));
		run_phase(110, 25, 900);
		set_config('1, '1);
		run_phase(70, 30, POOL_MAX);
		set_config(LEN_W'(64), MAXE_W'(0));
		run_phase(70, 30, 70);
		set_config(LEN_W'($urandom_range(1, 3000)), MAXE_W'($urandom_range(1, 16)));
		write_reg(CFG_SPARE, LEN_W'($urandom));
		cfg_valid <= 1'b0;
		run_phase(90, 35, 1500);
		set_config(LEN_W'(1000), MAXE_W'(16));
		run_phase(40, 0, 60);
		set_config(LEN_W'(1000), MAXE_W'(3));
		run_phase(50, 30, 300);
		set_config('0, MAXE_W'(16));
		run_phase(15, 40, 100);
		set_config(LEN_W'($urandom_range(1, POOL_MAX)), MAXE_W'($urandom_range(1, 31)));
		run_phase(80, 30, 400000);

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Requests: %0d placed, %0d rejected, %0d pulled, %0d empty pulls.",
		         sb.n_placed, sb.n_rejected, sb.n_pulled, sb.n_empty);
		$display("Register writes: %0d; largest eviction in one push: %0d.",
		         sb.n_cfg, sb.most_evicted);
		if (sb.fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
sv/rfdm_pkg.sv
sv/rfdm_front.sv
sv/rfdm_queue.sv
sv/rfdm_back.sv
sv/ring_frame_descriptor_manager_top.sv
sv/rfdm_checker.sv
sim/tb.sv
